FILE: rtl/core/dhom_pkg.sv
// ----------------------------------------------------------------------------
// dhom_pkg: shared definitions of the dual heartbeat offline monitor
// Register map indexes, field widths, reset values and default sizes.
// ----------------------------------------------------------------------------
package dhom_pkg;

	// Default sizes of the heartbeat counters and of the miss counters.
	localparam int DEF_BEAT_WIDTH  = 16;
	localparam int DEF_COUNT_WIDTH = 16;

	// Configuration bus sizes.
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// Register field widths.
	localparam int THRESH_W = 16;
	localparam int ENABLE_W = 2;
	localparam int CODE_W   = 4;

	// The judge count is threshold * 1000 / (10 * 50); the factor is exact.
	localparam int TIME_NUM   = 1000;
	localparam int TIME_DIV   = 10 * 50;
	localparam int JUDGE_MUL  = TIME_NUM / TIME_DIV;
	localparam int JUDGE_W    = THRESH_W + 1;

	// Reset values of the registers.
	localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(20);
	localparam logic [ENABLE_W-1:0] ENABLE_RESET = '0;
	localparam logic [CODE_W-1:0]   CODE_RESET   = '0;

	// Register indexes, taken from address bits [3:2].
	typedef enum logic [1:0] {
		REG_MISS_THRESHOLD = 2'd0,
		REG_LINK_ENABLE    = 2'd1,
		REG_WORKING_CODE   = 2'd2,
		REG_STOPPED_CODE   = 2'd3
	} reg_idx_t;

	// Number of monitored links.
	localparam int NUM_LINKS = 2;

endpackage

FILE: rtl/core/dual_heartbeat_offline_monitor_core.sv
// ----------------------------------------------------------------------------
// dual_heartbeat_offline_monitor_core: heartbeat loss watchdog for two links
// Samples two heartbeat counters per tick, counts unchanged samples, flags
// lost links and issues shutdown and bootup requests from the machine state.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake            | Word
//  ---------+----------------------+--------------------------------------------
//  in       | in_valid / in_stall  | beat_first, beat_second, machine_state
//  out      | out_valid / out_stall| first_offline, second_offline,
//           |                      | shutdown_pulse, bootup_pulse, shutdown_held
//  cfg      | APB psel / penable   | paddr, pwdata, prdata, pready
//
// One word is accepted per cycle while in_stall is low; the input register loads
// on acceptance, the result register when the judging stage advances.
// The single judging stage between the two registers sets the rate: it
// updates the slots, miss counters and latch once per word.
// A full result register under out_stall holds the judging stage, which in
// turn raises in_stall once the input register is full.
// Reset clears all watchdog state and loads the register reset values.
module dual_heartbeat_offline_monitor_core #(
	parameter int BEAT_WIDTH  = dhom_pkg::DEF_BEAT_WIDTH,
	parameter int COUNT_WIDTH = dhom_pkg::DEF_COUNT_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [BEAT_WIDTH-1:0]         beat_first,
	input  logic [BEAT_WIDTH-1:0]         beat_second,
	input  logic [dhom_pkg::CODE_W-1:0]   machine_state,
	// Output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          first_offline,
	output logic                          second_offline,
	output logic                          shutdown_pulse,
	output logic                          bootup_pulse,
	output logic                          shutdown_held,
	// Configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dhom_pkg::ADDR_W-1:0]   paddr,
	input  logic [dhom_pkg::DATA_W-1:0]   pwdata,
	output logic [dhom_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import dhom_pkg::*;

	localparam int CMP_W = (COUNT_WIDTH > JUDGE_W) ? COUNT_WIDTH : JUDGE_W;

	// Configuration registers
	logic [THRESH_W-1:0] miss_threshold_q;
	logic [ENABLE_W-1:0] link_enable_q;
	logic [CODE_W-1:0]   working_code_q;
	logic [CODE_W-1:0]   stopped_code_q;
	reg_idx_t            reg_idx;
	logic                cfg_write;

	// Input register
	logic                  valid_s1;
	logic [BEAT_WIDTH-1:0] beat_s1 [NUM_LINKS];
	logic [CODE_W-1:0]     state_s1;
	logic                  advance;

	// Watchdog state
	logic                   phase_q;
	logic [BEAT_WIDTH-1:0]  slot_a_q [NUM_LINKS];
	logic [BEAT_WIDTH-1:0]  slot_b_q [NUM_LINKS];
	logic [COUNT_WIDTH-1:0] misses_q [NUM_LINKS];
	logic [NUM_LINKS-1:0]   down_q;
	logic                   latch_q;

	// Next-state values of the judging stage
	logic                   phase_d;
	logic [BEAT_WIDTH-1:0]  slot_a_d [NUM_LINKS];
	logic [BEAT_WIDTH-1:0]  slot_b_d [NUM_LINKS];
	logic [COUNT_WIDTH-1:0] misses_d [NUM_LINKS];
	logic [NUM_LINKS-1:0]   down_d;
	logic                   latch_d;
	logic                   shut_d;
	logic                   boot_d;
	logic [JUDGE_W-1:0]     judge;

	// Result register
	logic out_valid_q;
	logic first_offline_q;
	logic second_offline_q;
	logic shutdown_pulse_q;
	logic bootup_pulse_q;
	logic shutdown_held_q;

	// Register writes complete in the access phase; pready is always high.
	assign pready    = 1'b1;
	assign reg_idx   = reg_idx_t'(paddr[3:2]);
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_threshold_q <= THRESH_RESET;
			link_enable_q    <= ENABLE_RESET;
			working_code_q   <= CODE_RESET;
			stopped_code_q   <= CODE_RESET;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_MISS_THRESHOLD: miss_threshold_q <= pwdata[THRESH_W-1:0];
				REG_LINK_ENABLE:    link_enable_q    <= pwdata[ENABLE_W-1:0];
				REG_WORKING_CODE:   working_code_q   <= pwdata[CODE_W-1:0];
				REG_STOPPED_CODE:   stopped_code_q   <= pwdata[CODE_W-1:0];
				default: ;
			endcase
		end
	end

	// Read data follows the address.
	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_MISS_THRESHOLD: prdata = DATA_W'(miss_threshold_q);
			REG_LINK_ENABLE:    prdata = DATA_W'(link_enable_q);
			REG_WORKING_CODE:   prdata = DATA_W'(working_code_q);
			REG_STOPPED_CODE:   prdata = DATA_W'(stopped_code_q);
			default:            prdata = '0;
		endcase
	end

	// The judging stage moves on whenever the result register is free or drains.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			beat_s1[0] <= beat_first;
			beat_s1[1] <= beat_second;
			state_s1   <= machine_state;
		end
	end

	// Judge count in ticks, exact at JUDGE_W bits.
	assign judge = JUDGE_W'(miss_threshold_q) * JUDGE_W'(JUDGE_MUL);

	// Per-link slot update and miss counting.
	always_comb begin
		phase_d = ~phase_q;
		for (int i = 0; i < NUM_LINKS; i++) begin
			slot_a_d[i] = phase_d ? beat_s1[i] : slot_a_q[i];
			slot_b_d[i] = phase_d ? slot_b_q[i] : beat_s1[i];
			if (link_enable_q[i] && (slot_a_d[i] == slot_b_d[i])) begin
				down_d[i]   = down_q[i] || (CMP_W'(misses_q[i]) > CMP_W'(judge));
				misses_d[i] = (&misses_q[i]) ? misses_q[i] : misses_q[i] + 1'b1;
			end else begin
				down_d[i]   = 1'b0;
				misses_d[i] = '0;
			end
		end
	end

	// Shutdown and bootup requests with the shutdown latch.
	always_comb begin
		shut_d  = 1'b0;
		boot_d  = 1'b0;
		latch_d = latch_q;
		if ((|down_d) && !latch_q && (state_s1 == working_code_q)) begin
			shut_d  = 1'b1;
			latch_d = 1'b1;
		end
		if (!(|down_d) && latch_d && (state_s1 == stopped_code_q)) begin
			boot_d  = 1'b1;
			latch_d = 1'b0;
		end
	end

	// Watchdog state commits when a word leaves the judging stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			down_q  <= '0;
			latch_q <= 1'b0;
			for (int i = 0; i < NUM_LINKS; i++) begin
				slot_a_q[i] <= '0;
				slot_b_q[i] <= '0;
				misses_q[i] <= '0;
			end
		end else if (valid_s1 && advance) begin
			phase_q <= phase_d;
			down_q  <= down_d;
			latch_q <= latch_d;
			for (int i = 0; i < NUM_LINKS; i++) begin
				slot_a_q[i] <= slot_a_d[i];
				slot_b_q[i] <= slot_b_d[i];
				misses_q[i] <= misses_d[i];
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			first_offline_q  <= down_d[0];
			second_offline_q <= down_d[1];
			shutdown_pulse_q <= shut_d;
			bootup_pulse_q   <= boot_d;
			shutdown_held_q  <= latch_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign first_offline  = first_offline_q;
	assign second_offline = second_offline_q;
	assign shutdown_pulse = shutdown_pulse_q;
	assign bootup_pulse   = bootup_pulse_q;
	assign shutdown_held  = shutdown_held_q;

endmodule

FILE: rtl/core/dhom_checker.sv
// ----------------------------------------------------------------------------
// dhom_checker: port-level checks of the heartbeat offline monitor
// Watches the result channel and the relation of pulses to the latch.
// ----------------------------------------------------------------------------
module dhom_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic first_offline,
	input logic second_offline,
	input logic shutdown_pulse,
	input logic bootup_pulse,
	input logic shutdown_held
);

	// A word never requests shutdown and bootup together.
	a_pulse_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(shutdown_pulse && bootup_pulse))
		else $error("shutdown and bootup pulse in the same word");

	// A shutdown request always leaves the latch set with a link offline.
	a_shut_latch: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && shutdown_pulse) |->
			(shutdown_held && (first_offline || second_offline)))
		else $error("shutdown pulse without latch or lost link");

	// A bootup request releases the latch with both links online.
	a_boot_release: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bootup_pulse) |->
			(!shutdown_held && !first_offline && !second_offline))
		else $error("bootup pulse with latch held or link offline");

	// A stalled result word stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(first_offline)
			&& $stable(second_offline) && $stable(shutdown_pulse)
			&& $stable(bootup_pulse) && $stable(shutdown_held)))
		else $error("stalled result word changed");

endmodule

bind dual_heartbeat_offline_monitor_core dhom_checker u_dhom_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.first_offline  (first_offline),
	.second_offline (second_offline),
	.shutdown_pulse (shutdown_pulse),
	.bootup_pulse   (bootup_pulse),
	.shutdown_held  (shutdown_held)
);
